FILE: src/radix2_fft_butterfly_stage_defines.svh
// ----------------------------------------------------------------------------
// radix2_fft_butterfly_stage_defines
// Assertion macros used by the butterfly pipeline RTL.
// ----------------------------------------------------------------------------
`ifndef RADIX2_FFT_BUTTERFLY_STAGE_DEFINES_SVH
`define RADIX2_FFT_BUTTERFLY_STAGE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define R2FFT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("r2fft assertion failed");

// Next-cycle implication
`define R2FFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("r2fft assertion failed");

`else

`define R2FFT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define R2FFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types and codes for the radix-2 butterfly stage.
// ----------------------------------------------------------------------------
`default_nettype none

package r2fft_pkg;

    // Stage modes
    localparam logic [1:0] MODE_FIRST_CPLX = 2'd0;
    localparam logic [1:0] MODE_FIRST_REAL = 2'd1;
    localparam logic [1:0] MODE_MIDDLE     = 2'd2;

    // Item commands
    localparam logic CMD_TW_WRITE = 1'b0;
    localparam logic CMD_BFLY     = 1'b1;

    // Register indexes (word address)
    localparam logic [1:0] REG_STAGE_MODE       = 2'd0;
    localparam logic [1:0] REG_LOG2_SIGNAL_LEN  = 2'd1;
    localparam logic [1:0] REG_LOG2_WARP_LEN    = 2'd2;
    localparam logic [1:0] REG_LOG2_STORE_PITCH = 2'd3;

    // Twiddle memory geometry
    localparam int TW_DEPTH = 512;
    localparam int TW_AW    = 9;

    // Maximum transform length; destination addresses wrap at this size
    localparam int MAX_LEN = 1024;

    // Wide enough for any address expression before wrapping
    localparam int CALC_W = 26;

    // Register file contents
    typedef struct packed {
        logic [1:0] stage_mode;
        logic [3:0] log2_signal_len;
        logic [3:0] log2_warp_len;
        logic [3:0] log2_store_pitch;
    } t_cfg;

endpackage

`default_nettype wire

FILE: src/r2fft_in_if.sv
// ----------------------------------------------------------------------------
// r2fft_in_if
// Input item channel: command, index, operands and twiddle data.
// ----------------------------------------------------------------------------
`default_nettype none

interface r2fft_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic        [8:0]  index;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
    logic signed [15:0] w_re;
    logic signed [15:0] w_im;

    modport source (
        output valid, cmd, index, a_re, a_im, b_re, b_im, w_re, w_im,
        input  ready
    );

    modport sink (
        input  valid, cmd, index, a_re, a_im, b_re, b_im, w_re, w_im,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/r2fft_out_if.sv
// ----------------------------------------------------------------------------
// r2fft_out_if
// Result item channel: butterfly outputs and destination addresses.
// ----------------------------------------------------------------------------
`default_nettype none

interface r2fft_out_if #(
    parameter int ADDR_W = 10
);
    logic               valid;
    logic               ready;
    logic signed [17:0] sum_re;
    logic signed [17:0] sum_im;
    logic signed [17:0] diff_re;
    logic signed [17:0] diff_im;
    logic [ADDR_W-1:0]  sum_addr;
    logic [ADDR_W-1:0]  diff_addr;

    modport source (
        output valid, sum_re, sum_im, diff_re, diff_im, sum_addr, diff_addr,
        input  ready
    );

    modport sink (
        input  valid, sum_re, sum_im, diff_re, diff_im, sum_addr, diff_addr,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/r2fft_tw_ram.sv
// ----------------------------------------------------------------------------
// r2fft_tw_ram
// Twiddle memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module r2fft_tw_ram (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [r2fft_pkg::TW_AW-1:0]  i_waddr,
    input  wire logic [31:0]                  i_wdata,
    input  wire logic                         i_re,
    input  wire logic [r2fft_pkg::TW_AW-1:0]  i_raddr,
    output logic      [31:0]                  o_rdata
);

    logic [31:0] r_mem [r2fft_pkg::TW_DEPTH];
    logic [31:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/r2fft_cfg_regs.sv
// ----------------------------------------------------------------------------
// r2fft_cfg_regs
// APB register file for stage mode and log2 size settings.
// ----------------------------------------------------------------------------
`default_nettype none

module r2fft_cfg_regs (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output r2fft_pkg::t_cfg        o_cfg
);

    r2fft_pkg::t_cfg r_cfg;
    logic            wr_en;
    logic [1:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stage_mode       <= r2fft_pkg::MODE_FIRST_CPLX;
            r_cfg.log2_signal_len  <= 4'd10;
            r_cfg.log2_warp_len    <= 4'd1;
            r_cfg.log2_store_pitch <= 4'd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                r2fft_pkg::REG_STAGE_MODE:       r_cfg.stage_mode       <= pwdata[1:0];
                r2fft_pkg::REG_LOG2_SIGNAL_LEN:  r_cfg.log2_signal_len  <= pwdata[3:0];
                r2fft_pkg::REG_LOG2_WARP_LEN:    r_cfg.log2_warp_len    <= pwdata[3:0];
                r2fft_pkg::REG_LOG2_STORE_PITCH: r_cfg.log2_store_pitch <= pwdata[3:0];
                default:                         r_cfg                  <= r_cfg;
            endcase
        end
    end

    // Readback
    always_comb begin
        unique case (reg_idx)
            r2fft_pkg::REG_STAGE_MODE:       prdata = {30'd0, r_cfg.stage_mode};
            r2fft_pkg::REG_LOG2_SIGNAL_LEN:  prdata = {28'd0, r_cfg.log2_signal_len};
            r2fft_pkg::REG_LOG2_WARP_LEN:    prdata = {28'd0, r_cfg.log2_warp_len};
            r2fft_pkg::REG_LOG2_STORE_PITCH: prdata = {28'd0, r_cfg.log2_store_pitch};
            default:                         prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: src/r2fft_bfly_pipe.sv
// ----------------------------------------------------------------------------
// r2fft_bfly_pipe
// Three-stage butterfly pipeline: address and twiddle fetch, complex
// multiply, round and add/subtract into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radix2_fft_butterfly_stage_defines.svh"

module r2fft_bfly_pipe (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire r2fft_pkg::t_cfg i_cfg,
    r2fft_in_if.sink             i_in,
    r2fft_out_if.source          o_out
);

    localparam int AddrW = $clog2(r2fft_pkg::MAX_LEN);
    localparam int CalcW = r2fft_pkg::CALC_W;
    localparam int TwAW  = r2fft_pkg::TW_AW;

    // Handshake and stage advance
    logic adv1, adv2, adv3;
    logic in_fire, is_bfly, bypass;

    logic r_s1_v, r_s2_v, r_s3_v;

    // Stage 1 payload
    logic signed [15:0] r_s1_a_re, r_s1_a_im, r_s1_b_re, r_s1_b_im;
    logic               r_s1_bypass;
    logic [AddrW-1:0]   r_s1_saddr, r_s1_daddr;
    logic [31:0]        tw_rdata;

    // Stage 2 payload
    logic signed [15:0] r_s2_a_re, r_s2_a_im, r_s2_b_re, r_s2_b_im;
    logic signed [31:0] r_s2_p_rr, r_s2_p_ii, r_s2_p_ri, r_s2_p_ir;
    logic               r_s2_bypass;
    logic [AddrW-1:0]   r_s2_saddr, r_s2_daddr;

    // Result register
    logic signed [17:0] r_s3_sum_re, r_s3_sum_im, r_s3_diff_re, r_s3_diff_im;
    logic [AddrW-1:0]   r_s3_saddr, r_s3_daddr;

    // Stage 0 combinational
    logic [TwAW-1:0]   n_pmask, n_loc, n_hi, n_tw_idx;
    logic [3:0]        n_shift;
    logic [CalcW-1:0]  n_mid_sum, n_mid_diff, n_first_sum, n_first_diff, n_pitch;
    logic [AddrW-1:0]  n_saddr, n_daddr;
    logic signed [15:0] n_a_im, n_b_im;

    // Stage 2 products
    logic signed [15:0] tw_re, tw_im;
    logic signed [31:0] n_p_rr, n_p_ii, n_p_ri, n_p_ir;

    // Stage 3 combinational
    logic signed [32:0] n_acc_re, n_acc_im;
    logic signed [17:0] n_t_re, n_t_im;
    logic signed [17:0] n_sum_re, n_sum_im, n_diff_re, n_diff_im;
    logic signed [17:0] a_re_x, a_im_x;

    assign adv3       = !r_s3_v || o_out.ready;
    assign adv2       = !r_s2_v || adv3;
    assign adv1       = !r_s1_v || adv2;
    assign i_in.ready = adv1;
    assign in_fire    = i_in.valid && adv1;
    assign is_bfly    = (i_in.cmd == r2fft_pkg::CMD_BFLY);
    assign bypass     = (i_cfg.stage_mode == r2fft_pkg::MODE_FIRST_CPLX) ||
                        (i_cfg.stage_mode == r2fft_pkg::MODE_FIRST_REAL);

    // Address and twiddle index generation
    always_comb begin
        n_pmask  = (TwAW'(1) << i_cfg.log2_store_pitch) - TwAW'(1);
        n_loc    = i_in.index & n_pmask;
        n_hi     = i_in.index >> i_cfg.log2_store_pitch;
        n_shift  = i_cfg.log2_signal_len - i_cfg.log2_warp_len;
        n_tw_idx = (i_cfg.log2_signal_len >= i_cfg.log2_warp_len) ?
                   (n_loc << n_shift) : '0;
        n_pitch      = CalcW'(1) << i_cfg.log2_store_pitch;
        n_mid_sum    = (CalcW'(n_hi) << i_cfg.log2_warp_len) + CalcW'(n_loc);
        n_mid_diff   = n_mid_sum + n_pitch;
        n_first_sum  = CalcW'(i_in.index) << 1;
        n_first_diff = n_first_sum + CalcW'(1);
        n_saddr = bypass ? n_first_sum[AddrW-1:0]  : n_mid_sum[AddrW-1:0];
        n_daddr = bypass ? n_first_diff[AddrW-1:0] : n_mid_diff[AddrW-1:0];
        // Real input: imaginary parts forced to zero
        n_a_im = (i_cfg.stage_mode == r2fft_pkg::MODE_FIRST_REAL) ? 16'sd0 : i_in.a_im;
        n_b_im = (i_cfg.stage_mode == r2fft_pkg::MODE_FIRST_REAL) ? 16'sd0 : i_in.b_im;
    end

    // Twiddle memory: written by twiddle items, read by butterfly items
    r2fft_tw_ram u_tw_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && !is_bfly),
        .i_waddr (i_in.index),
        .i_wdata ({i_in.w_re, i_in.w_im}),
        .i_re    (in_fire && is_bfly),
        .i_raddr (n_tw_idx),
        .o_rdata (tw_rdata)
    );

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (adv1) begin
                r_s1_v <= in_fire && is_bfly;
            end
            if (adv2) begin
                r_s2_v <= r_s1_v;
            end
            if (adv3) begin
                r_s3_v <= r_s2_v;
            end
        end
    end

    // Stage 1 capture
    always_ff @(posedge i_clk) begin
        if (in_fire && is_bfly) begin
            r_s1_a_re   <= i_in.a_re;
            r_s1_a_im   <= n_a_im;
            r_s1_b_re   <= i_in.b_re;
            r_s1_b_im   <= n_b_im;
            r_s1_bypass <= bypass;
            r_s1_saddr  <= n_saddr;
            r_s1_daddr  <= n_daddr;
        end
    end

    // Complex multiply partial products
    assign tw_re = tw_rdata[31:16];
    assign tw_im = tw_rdata[15:0];

    always_comb begin
        n_p_rr = 32'(r_s1_b_re) * 32'(tw_re);
        n_p_ii = 32'(r_s1_b_im) * 32'(tw_im);
        n_p_ri = 32'(r_s1_b_re) * 32'(tw_im);
        n_p_ir = 32'(r_s1_b_im) * 32'(tw_re);
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_s1_v) begin
            r_s2_p_rr   <= n_p_rr;
            r_s2_p_ii   <= n_p_ii;
            r_s2_p_ri   <= n_p_ri;
            r_s2_p_ir   <= n_p_ir;
            r_s2_a_re   <= r_s1_a_re;
            r_s2_a_im   <= r_s1_a_im;
            r_s2_b_re   <= r_s1_b_re;
            r_s2_b_im   <= r_s1_b_im;
            r_s2_bypass <= r_s1_bypass;
            r_s2_saddr  <= r_s1_saddr;
            r_s2_daddr  <= r_s1_daddr;
        end
    end

    // Round half up and shift by 15 (b passed through in first stages), then sum and difference
    always_comb begin
        n_acc_re  = 33'(r_s2_p_rr) - 33'(r_s2_p_ii) + 33'sd16384;
        n_acc_im  = 33'(r_s2_p_ri) + 33'(r_s2_p_ir) + 33'sd16384;
        n_t_re    = r_s2_bypass ? 18'(r_s2_b_re) : n_acc_re[32:15];
        n_t_im    = r_s2_bypass ? 18'(r_s2_b_im) : n_acc_im[32:15];
        a_re_x    = 18'(r_s2_a_re);
        a_im_x    = 18'(r_s2_a_im);
        n_sum_re  = a_re_x + n_t_re;
        n_sum_im  = a_im_x + n_t_im;
        n_diff_re = a_re_x - n_t_re;
        n_diff_im = a_im_x - n_t_im;
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r_s2_v) begin
            r_s3_sum_re  <= n_sum_re;
            r_s3_sum_im  <= n_sum_im;
            r_s3_diff_re <= n_diff_re;
            r_s3_diff_im <= n_diff_im;
            r_s3_saddr   <= r_s2_saddr;
            r_s3_daddr   <= r_s2_daddr;
        end
    end

    assign o_out.valid     = r_s3_v;
    assign o_out.sum_re    = r_s3_sum_re;
    assign o_out.sum_im    = r_s3_sum_im;
    assign o_out.diff_re   = r_s3_diff_re;
    assign o_out.diff_im   = r_s3_diff_im;
    assign o_out.sum_addr  = r_s3_saddr;
    assign o_out.diff_addr = r_s3_daddr;

    // Checks
    `R2FFT_ASSERT_NEXT(a_bfly_enters_s1, i_clk, i_rst_n, in_fire && is_bfly, r_s1_v)
    `R2FFT_ASSERT_IMPLY(a_ready_when_s1_empty, i_clk, i_rst_n, !r_s1_v, i_in.ready)
    `R2FFT_ASSERT_IMPLY(a_real_im_zero, i_clk, i_rst_n, o_out.valid && (i_cfg.stage_mode == r2fft_pkg::MODE_FIRST_REAL), (o_out.sum_im == 18'sd0) && (o_out.diff_im == 18'sd0))
    `R2FFT_ASSERT_IMPLY(a_first_addr_pair, i_clk, i_rst_n, o_out.valid && bypass, o_out.diff_addr == (o_out.sum_addr + AddrW'(1)))
    `R2FFT_ASSERT_IMPLY(a_mid_addr_pitch, i_clk, i_rst_n, o_out.valid && !bypass, o_out.diff_addr == (o_out.sum_addr + n_pitch[AddrW-1:0]))

endmodule

`default_nettype wire

FILE: src/radix2_fft_butterfly_stage.sv
// ----------------------------------------------------------------------------
// radix2_fft_butterfly_stage
// o_out.valid rises once an accepted item has passed the twiddle read,
//   product and result registers.
// Throughput: one item per cycle; input stalls only with all three stages
//   full and the result not taken. Twiddle writes give no result.
// Reset: synchronous active-low; clears valid bits and config registers to
//   their defaults. The twiddle memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module radix2_fft_butterfly_stage (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    r2fft_in_if.sink         i_in,
    r2fft_out_if.source      o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    r2fft_pkg::t_cfg cfg;

    // Configuration registers
    r2fft_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Butterfly datapath
    r2fft_bfly_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

FILE: bench/radix2_fft_butterfly_stage_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix2_fft_butterfly_stage_tb
// Self-checking bench for the radix-2 butterfly stage. Items are fed through
// the input channel with random gaps, twiddle entries are loaded before any
// butterfly reads them, and each result is checked against a local
// fixed-point model of the stage. The four APB registers are rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------

module radix2_fft_butterfly_stage_tb;

    localparam logic [1:0] MODE_SPARE = 2'd3;   // unused selector, acts as middle stage
    localparam int ADDR_MASK     = 1023;        // MAX_LEN - 1
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_ITEMS   = 40;

    typedef struct packed {
        logic               cmd;
        logic        [8:0]  index;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
        logic signed [15:0] w_re;
        logic signed [15:0] w_im;
    } t_op_item;

    typedef struct packed {
        logic signed [17:0] sum_re;
        logic signed [17:0] sum_im;
        logic signed [17:0] diff_re;
        logic signed [17:0] diff_im;
        logic        [9:0]  sum_addr;
        logic        [9:0]  diff_addr;
    } t_bfly_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    r2fft_in_if                 in_if ();
    r2fft_out_if #(.ADDR_W(10)) out_if ();

    radix2_fft_butterfly_stage i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Stage state as seen by the checker
    r2fft_pkg::t_cfg     cfg_now;
    logic signed [15:0]  tw_re_copy [r2fft_pkg::TW_DEPTH];
    logic signed [15:0]  tw_im_copy [r2fft_pkg::TW_DEPTH];
    bit                  tw_loaded  [r2fft_pkg::TW_DEPTH];

    t_op_item            items_to_send[$];
    t_bfly_result        butterfly_results_due[$];

    int  cycle_count = 0;
    int  fault_count = 0;
    int  send_gap    = 0;
    int  stall_gap   = 0;
    bit  send_taken  = 1'b0;
    bit  steady_run  = 1'b0;

    // Clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Twiddle entry a middle-stage butterfly reads
    function automatic int unsigned tw_slot(input r2fft_pkg::t_cfg c, input logic [8:0] idx);
        longint unsigned loc;
        longint unsigned scale;
        loc   = idx & ((64'd1 << c.log2_store_pitch) - 1);
        scale = 0;
        if (c.log2_signal_len >= c.log2_warp_len)
            scale = 64'd1 << (c.log2_signal_len - c.log2_warp_len);
        return int'((scale * loc) % r2fft_pkg::TW_DEPTH);
    endfunction

    function automatic bit is_first_stage(input r2fft_pkg::t_cfg c);
        return c.stage_mode == r2fft_pkg::MODE_FIRST_CPLX ||
               c.stage_mode == r2fft_pkg::MODE_FIRST_REAL;
    endfunction

    // Updates the twiddle copy, or works out the butterfly the block must return
    function automatic void compute_butterfly(input t_op_item it);
        longint       are, aim, bre, bim, wre, wim, tre, tim;
        longint       pitch, warp, loc, saddr, daddr;
        int unsigned  slot;
        t_bfly_result res;
        if (it.cmd == r2fft_pkg::CMD_TW_WRITE) begin
            tw_re_copy[it.index] = it.w_re;
            tw_im_copy[it.index] = it.w_im;
            return;
        end
        are = it.a_re;
        aim = it.a_im;
        bre = it.b_re;
        bim = it.b_im;
        if (is_first_stage(cfg_now)) begin
            if (cfg_now.stage_mode == r2fft_pkg::MODE_FIRST_REAL) begin
                aim = 0;
                bim = 0;
            end
            tre   = bre;
            tim   = bim;
            saddr = (2 * longint'(it.index)) & ADDR_MASK;
            daddr = (2 * longint'(it.index) + 1) & ADDR_MASK;
        end else begin
            pitch = longint'(1) << cfg_now.log2_store_pitch;
            warp  = longint'(1) << cfg_now.log2_warp_len;
            loc   = longint'(it.index) & (pitch - 1);
            slot  = tw_slot(cfg_now, it.index);
            wre   = tw_re_copy[slot];
            wim   = tw_im_copy[slot];
            // round half up, arithmetic shift
            tre   = (bre * wre - bim * wim + 16384) >>> 15;
            tim   = (bre * wim + bim * wre + 16384) >>> 15;
            saddr = (longint'(it.index) >> cfg_now.log2_store_pitch) * warp + loc;
            daddr = (saddr + pitch) & ADDR_MASK;
            saddr = saddr & ADDR_MASK;
        end
        res.sum_re    = 18'(are + tre);
        res.sum_im    = 18'(aim + tim);
        res.diff_re   = 18'(are - tre);
        res.diff_im   = 18'(aim - tim);
        res.sum_addr  = 10'(saddr);
        res.diff_addr = 10'(daddr);
        butterfly_results_due.push_back(res);
    endfunction

    // Q1.15 operand that often lands on an extreme
    function automatic logic signed [15:0] rand_q15();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_twiddle(input logic [8:0] idx, input logic signed [15:0] wr,
                                input logic signed [15:0] wi);
        t_op_item it;
        it = '{r2fft_pkg::CMD_TW_WRITE, idx, rand_q15(), rand_q15(), rand_q15(),
               rand_q15(), wr, wi};
        tw_loaded[idx] = 1'b1;
        items_to_send.push_back(it);
    endtask

    // Loads the needed twiddle first so no unwritten entry is ever read
    task automatic push_butterfly(input logic [8:0] idx,
                                  input logic signed [15:0] ar, input logic signed [15:0] ai,
                                  input logic signed [15:0] br, input logic signed [15:0] bi);
        t_op_item    it;
        int unsigned slot;
        slot = tw_slot(cfg_now, idx);
        if (!is_first_stage(cfg_now) && !tw_loaded[slot])
            push_twiddle(9'(slot), rand_q15(), rand_q15());
        it = '{r2fft_pkg::CMD_BFLY, idx, ar, ai, br, bi, 16'($urandom), 16'($urandom)};
        items_to_send.push_back(it);
    endtask

    // APB write; psel is left high so writes can go back to back
    task automatic reg_write(input logic [1:0] reg_idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (reg_idx)
            r2fft_pkg::REG_STAGE_MODE:       cfg_now.stage_mode       = value[1:0];
            r2fft_pkg::REG_LOG2_SIGNAL_LEN:  cfg_now.log2_signal_len  = value[3:0];
            r2fft_pkg::REG_LOG2_WARP_LEN:    cfg_now.log2_warp_len    = value[3:0];
            r2fft_pkg::REG_LOG2_STORE_PITCH: cfg_now.log2_store_pitch = value[3:0];
            default: ;
        endcase
    endtask

    // Wait until every item is in and every result is out, then let the pipe empty
    task automatic drain();
        do @(posedge i_clk);
        while (items_to_send.size() != 0 || butterfly_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_stage(input logic [1:0] mode, input logic [3:0] len,
                             input logic [3:0] warp, input logic [3:0] pitch);
        drain();
        reg_write(r2fft_pkg::REG_STAGE_MODE,       32'(mode));
        reg_write(r2fft_pkg::REG_LOG2_SIGNAL_LEN,  32'(len));
        reg_write(r2fft_pkg::REG_LOG2_WARP_LEN,    32'(warp));
        reg_write(r2fft_pkg::REG_LOG2_STORE_PITCH, 32'(pitch));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Input driver: holds an item until taken, random gaps between items
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && !send_taken) begin
            // still waiting for ready
        end else if (send_gap > 0) begin
            in_if.valid <= 1'b0;
            send_gap--;
        end else if (!steady_run && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            send_gap = $urandom_range(1, 11) - 1;
        end else if (items_to_send.size() != 0) begin
            in_if.valid <= 1'b1;
            in_if.cmd   <= items_to_send[0].cmd;
            in_if.index <= items_to_send[0].index;
            in_if.a_re  <= items_to_send[0].a_re;
            in_if.a_im  <= items_to_send[0].a_im;
            in_if.b_re  <= items_to_send[0].b_re;
            in_if.b_im  <= items_to_send[0].b_im;
            in_if.w_re  <= items_to_send[0].w_re;
            in_if.w_im  <= items_to_send[0].w_im;
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    // Result receiver: random stall bursts
    always @(negedge i_clk) begin
        if (stall_gap > 0) begin
            out_if.ready <= 1'b0;
            stall_gap--;
        end else if (!steady_run && $urandom_range(0, 5) == 0) begin
            out_if.ready <= 1'b0;
            stall_gap = $urandom_range(1, 11) - 1;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Accepted input items feed the model
    always @(posedge i_clk) begin
        t_op_item it;
        send_taken = i_rst_n && in_if.valid === 1'b1 && in_if.ready === 1'b1;
        if (send_taken) begin
            it = '{in_if.cmd, in_if.index, in_if.a_re, in_if.a_im,
                   in_if.b_re, in_if.b_im, in_if.w_re, in_if.w_im};
            compute_butterfly(it);
            void'(items_to_send.pop_front());
        end
    end

    // Accepted results are checked against the oldest expectation
    always @(posedge i_clk) begin
        t_bfly_result got;
        t_bfly_result want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got = '{out_if.sum_re, out_if.sum_im, out_if.diff_re, out_if.diff_im,
                    out_if.sum_addr, out_if.diff_addr};
            if (butterfly_results_due.size() == 0) begin
                if (fault_count < 10)
                    $display("cycle %0d: result with none expected", cycle_count);
                fault_count++;
            end else begin
                want = butterfly_results_due.pop_front();
                if (got !== want) begin
                    if (fault_count < 10) begin
                        $display("cycle %0d: butterfly mismatch", cycle_count);
                        $display("  expected sum %0d %0d diff %0d %0d addr %0d %0d",
                                 want.sum_re, want.sum_im, want.diff_re, want.diff_im,
                                 want.sum_addr, want.diff_addr);
                        $display("  actual   sum %0d %0d diff %0d %0d addr %0d %0d",
                                 got.sum_re, got.sum_im, got.diff_re, got.diff_im,
                                 got.sum_addr, got.diff_addr);
                    end
                    fault_count++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        logic [1:0] mode;
        logic [3:0] len;
        logic [3:0] warp;
        logic [3:0] pitch;

        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_if.valid  = 1'b0;
        in_if.cmd    = r2fft_pkg::CMD_TW_WRITE;
        in_if.index  = '0;
        in_if.a_re   = '0;
        in_if.a_im   = '0;
        in_if.b_re   = '0;
        in_if.b_im   = '0;
        in_if.w_re   = '0;
        in_if.w_im   = '0;
        out_if.ready = 1'b0;
        cfg_now      = '{r2fft_pkg::MODE_FIRST_CPLX, 4'd10, 4'd1, 4'd0};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: first stage complex, twiddle loads with extremes
        push_twiddle(9'd0,   16'sh8000, 16'sh8000);
        push_twiddle(9'd511, 16'sh7FFF, 16'sh8000);
        push_twiddle(9'd1,   16'sh7FFF, 16'sh0000);
        push_butterfly(9'd0,   16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
        push_butterfly(9'd511, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        push_butterfly(9'd256, 16'sh0000, 16'sh0000, 16'shFFFF, 16'shFFFF);

        // First stage real: imaginary inputs dropped
        set_stage(r2fft_pkg::MODE_FIRST_REAL, 4'd10, 4'd1, 4'd0);
        push_butterfly(9'd5,   16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        push_butterfly(9'd511, 16'sh7FFF, 16'shFFFF, 16'sh8000, 16'shFFFF);

        // Middle stage, table index wraps to entry 0
        set_stage(r2fft_pkg::MODE_MIDDLE, 4'd10, 4'd1, 4'd9);
        push_butterfly(9'd511, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
        push_butterfly(9'd3,   16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);

        // Spare selector, group span above length, address wrap
        set_stage(MODE_SPARE, 4'd1, 4'd10, 4'd0);
        push_butterfly(9'd511, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        push_butterfly(9'd300, 16'sh8000, 16'sh0001, 16'sh1234, 16'shEDCB);

        // Middle stage, unit scale, widest pitch
        set_stage(r2fft_pkg::MODE_MIDDLE, 4'd9, 4'd9, 4'd9);
        push_butterfly(9'd511, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
        push_butterfly(9'd1,   16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);

        // Random phases; the last one runs without idling
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       mode = r2fft_pkg::MODE_FIRST_CPLX;
                1:       mode = r2fft_pkg::MODE_FIRST_REAL;
                2:       mode = MODE_SPARE;
                default: mode = r2fft_pkg::MODE_MIDDLE;
            endcase
            len   = 4'($urandom_range(1, 10));
            warp  = 4'($urandom_range(1, 10));
            pitch = 4'($urandom_range(0, 9));
            set_stage(mode, len, warp, pitch);
            if (ph == RAND_PHASES - 1)
                steady_run = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 6) == 0)
                    push_twiddle(9'($urandom), rand_q15(), rand_q15());
                else
                    push_butterfly(9'($urandom), rand_q15(), rand_q15(),
                                   rand_q15(), rand_q15());
            end
        end

        drain();
        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
